FILE: src/ddpd_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive PD controller package
// Shared types, register map and fixed-point helpers.
// ----------------------------------------------------------------------------
package ddpd_pkg;

  localparam int NumRegs   = 8;
  localparam int RegIdxW   = 3;
  localparam int MotorMax  = 16384;

  localparam logic [RegIdxW-1:0] REG_DRIVE_P    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DRIVE_D    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_PIVOT_P    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_PIVOT_D    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HEADING    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_DEAD_ZONE  = 3'd5;
  localparam logic [RegIdxW-1:0] REG_DRIVE_CLMP = 3'd6;
  localparam logic [RegIdxW-1:0] REG_PIVOT_CLMP = 3'd7;

  localparam logic [15:0] RegReset [NumRegs] = '{
    16'd1638, 16'd45056, 16'd614, 16'd12288, 16'd225, 16'd164, 16'd768, 16'd1280
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DRIVE = 2'd1,
    OP_PIVOT = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_RESET  = 4'd1,
    ST_INIT   = 4'd2,
    ST_DSTART = 4'd3,
    ST_TELEOP = 4'd4,
    ST_DRIVE  = 4'd5,
    ST_DDONE  = 4'd6,
    ST_PSTART = 4'd7,
    ST_PIVOT  = 4'd8,
    ST_PDONE  = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CALC, PH_M1, PH_M2, PH_M3, PH_M4, PH_M5, PH_FIN
  } phase_t;

  typedef struct packed {
    logic   load;
    phase_t step;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic out_taken;
  } stat_t;

  typedef struct packed {
    logic signed [15:0] left_motor;
    logic signed [15:0] right_motor;
    logic               reset_encoders;
    logic               clear_gyro;
    mode_t              mode_code;
    logic               motion_done;
  } result_t;

  // Signed division by 2**k, truncating toward zero.
  function automatic logic signed [45:0] sdiv(input logic signed [45:0] x,
                                              input logic [3:0] k);
    logic signed [45:0] bias;
    bias = x[45] ? ((46'sd1 <<< k) - 46'sd1) : 46'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [15:0] sat_motor(input logic signed [45:0] x);
    logic signed [15:0] r;
    if (x > 46'sd16384) r = 16'sd16384;
    else if (x < -46'sd16384) r = -16'sd16384;
    else r = x[15:0];
    return r;
  endfunction

endpackage

FILE: src/ddpd_ctrl.sv
// ----------------------------------------------------------------------------
// Differential drive PD controller sequencer
// Steps the shared datapath through one item and hands over the result.
// ----------------------------------------------------------------------------
module ddpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ddpd_pkg::stat_t stat,
  output ddpd_pkg::cmd_t  cmd
);
  import ddpd_pkg::*;

  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = phase;
    cmd.commit = 1'b0;
    case (phase)
      PH_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          phase_next = PH_CALC;
        end
      end
      PH_CALC: phase_next = PH_M1;
      PH_M1:   phase_next = PH_M2;
      PH_M2:   phase_next = PH_M3;
      PH_M3:   phase_next = PH_M4;
      PH_M4:   phase_next = PH_M5;
      PH_M5:   phase_next = PH_FIN;
      PH_FIN: begin
        // Wait here until the output register has room for the new beat.
        if (!stat.out_full || stat.out_taken) begin
          cmd.commit = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

endmodule

FILE: src/ddpd_datapath.sv
// ----------------------------------------------------------------------------
// Differential drive PD controller datapath
// Holds the registers and controller state, and runs the PD arithmetic on
// one shared multiplier.
// ----------------------------------------------------------------------------
module ddpd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ddpd_pkg::cmd_t       cmd,
  input  logic [1:0]           in_op,
  input  logic [167:0]         in_data,
  input  logic                 cfg_we,
  input  logic [ddpd_pkg::RegIdxW-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output ddpd_pkg::result_t    result
);
  import ddpd_pkg::*;

  logic [15:0] regs [NumRegs];

  // Captured item
  op_t                op;
  logic signed [15:0] ls, rs, tspd;
  logic signed [23:0] ld, rd, gy, tdist, tang;

  // Controller state
  mode_t              mode, mode_next;
  logic               dreq, dreq_next, preq, preq_next, done, done_next;
  logic signed [23:0] goal_dist, goal_dist_next, goal_head, goal_head_next;
  logic signed [23:0] goal_piv, goal_piv_next, dlast, dlast_next, alast, alast_next;
  logic signed [15:0] goal_spd, goal_spd_next, held_l, held_l_next, held_r, held_r_next;
  logic               enc_pulse, gyro_pulse;

  // Intermediate values
  logic signed [25:0] ed, ep, ed_c, ep_c, eraw, praw, dclmp, plim;
  logic signed [26:0] dd, dp, dd_c, dp_c;
  logic signed [24:0] hdiff, gabs, sum;
  logic [24:0]        sabs;
  logic [23:0]        trav;
  logic               trav_ge, near_d, near64, near384;
  logic               trav_ge_c, near_d_c, near64_c, near384_c;
  logic signed [26:0] ma;
  logic signed [16:0] mb;
  logic signed [43:0] prod;
  logic signed [44:0] acc;
  logic signed [15:0] fac;
  logic signed [39:0] trim;
  logic signed [45:0] speed;
  logic [16:0]        labs, rabs;
  logic               piv;

  assign piv = (mode == ST_PIVOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= RegReset[i];
    end else if (cfg_we) begin
      regs[cfg_index] <= (cfg_index == REG_DEAD_ZONE) ? {1'b0, cfg_data[14:0]} : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= op_t'(in_op);
      ls    <= in_data[15:0];
      rs    <= in_data[31:16];
      ld    <= in_data[55:32];
      rd    <= in_data[79:56];
      gy    <= in_data[103:80];
      tdist <= in_data[127:104];
      tspd  <= in_data[143:128];
      tang  <= in_data[167:144];
    end
  end

  // Error terms from the captured readings
  always_comb begin
    sum   = 25'(ld) + 25'(rd);
    sabs  = sum[24] ? 25'(-sum) : 25'(sum);
    trav  = sabs[24:1];
    eraw  = 26'(goal_dist) - $signed({2'b00, trav});
    dclmp = $signed({10'd0, regs[REG_DRIVE_CLMP]});
    ed_c  = (eraw > dclmp) ? dclmp : eraw;
    dd_c  = (dlast <= 24'sd0) ? 27'sd0 : 27'(ed_c) - 27'(dlast);
    gabs  = goal_dist[23] ? -25'(goal_dist) : 25'(goal_dist);
    trav_ge_c = $signed({2'b00, trav}) >= 26'(gabs);
    near_d_c  = (eraw > -26'sd128) && (eraw < 26'sd128);
    praw  = 26'(gy) - 26'(goal_piv);
    plim  = $signed({10'd0, regs[REG_PIVOT_CLMP]});
    if (praw > plim) ep_c = plim;
    else if (praw < -plim) ep_c = -plim;
    else ep_c = praw;
    dp_c  = (alast <= 24'sd0) ? 27'sd0 : 27'(ep_c) - 27'(alast);
    near64_c  = (praw > -26'sd64) && (praw < 26'sd64);
    near384_c = (praw > -26'sd384) && (praw < 26'sd384);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      PH_M1: begin
        ma = piv ? 27'(ep) : 27'(ed);
        mb = $signed({1'b0, piv ? regs[REG_PIVOT_P] : regs[REG_DRIVE_P]});
      end
      PH_M2: begin
        ma = piv ? dp : dd;
        mb = $signed({1'b0, piv ? regs[REG_PIVOT_D] : regs[REG_DRIVE_D]});
      end
      PH_M3: begin
        ma = 27'(hdiff);
        mb = $signed({1'b0, regs[REG_HEADING]});
      end
      PH_M5: begin
        ma = 27'(fac);
        mb = 17'(goal_spd);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // The speed product must survive a stall in the write-back step.
    if (cmd.step != PH_FIN) prod <= ma * mb;
    case (cmd.step)
      PH_CALC: begin
        ed      <= ed_c;
        dd      <= dd_c;
        ep      <= ep_c;
        dp      <= dp_c;
        hdiff   <= 25'(gy) - 25'(goal_head);
        trav_ge <= trav_ge_c;
        near_d  <= near_d_c;
        near64  <= near64_c;
        near384 <= near384_c;
      end
      PH_M2: acc <= 45'(prod);
      PH_M3: acc <= acc + 45'(prod);
      PH_M4: begin
        fac  <= sat_motor(sdiv(46'(acc), piv ? 4'd5 : 4'd6));
        trim <= 40'(-sdiv(46'(prod), 4'd5));
      end
      default: ;
    endcase
  end

  assign speed = sdiv(46'(prod), 4'd14);
  assign labs  = ls[15] ? 17'(-17'(ls)) : 17'(ls);
  assign rabs  = rs[15] ? 17'(-17'(rs)) : 17'(rs);

  always_comb begin
    mode_next      = mode;
    dreq_next      = dreq;
    preq_next      = preq;
    done_next      = done;
    goal_dist_next = goal_dist;
    goal_head_next = goal_head;
    goal_piv_next  = goal_piv;
    goal_spd_next  = goal_spd;
    dlast_next     = dlast;
    alast_next     = alast;
    held_l_next    = held_l;
    held_r_next    = held_r;
    enc_pulse      = 1'b0;
    gyro_pulse     = 1'b0;
    case (op)
      OP_DRIVE: begin
        dreq_next      = 1'b1;
        done_next      = 1'b0;
        goal_dist_next = tdist;
        goal_spd_next  = tspd;
        goal_head_next = tang;
        enc_pulse      = 1'b1;
      end
      OP_PIVOT: begin
        preq_next     = 1'b1;
        done_next     = 1'b0;
        goal_piv_next = tang;
        goal_spd_next = tspd;
      end
      OP_RESET: begin
        mode_next      = ST_RESET;
        dreq_next      = 1'b0;
        preq_next      = 1'b0;
        goal_dist_next = '0;
      end
      default: begin
        case (mode)
          ST_IDLE: begin
            if (labs > {2'b00, regs[REG_DEAD_ZONE][14:0]} ||
                rabs > {2'b00, regs[REG_DEAD_ZONE][14:0]}) mode_next = ST_TELEOP;
            else if (dreq) mode_next = ST_DSTART;
            else if (preq) mode_next = ST_PSTART;
            else mode_next = ST_IDLE;
            done_next = 1'b0;
          end
          ST_RESET: begin
            held_l_next = '0;
            held_r_next = '0;
            enc_pulse   = 1'b1;
            gyro_pulse  = 1'b1;
            mode_next   = ST_INIT;
          end
          ST_INIT: begin
            enc_pulse      = 1'b1;
            dreq_next      = 1'b0;
            preq_next      = 1'b0;
            goal_dist_next = '0;
            done_next      = 1'b0;
            mode_next      = ST_IDLE;
          end
          ST_DSTART: begin
            held_l_next = 16'(MotorMax / 2);
            held_r_next = 16'(MotorMax / 2);
            enc_pulse   = 1'b1;
            mode_next   = ST_DRIVE;
          end
          ST_DRIVE: begin
            if (ed > 26'sd8388607) dlast_next = 24'sh7FFFFF;
            else if (ed < -26'sd8388608) dlast_next = 24'sh800000;
            else dlast_next = ed[23:0];
            held_l_next = sat_motor(speed + 46'(trim));
            held_r_next = sat_motor(speed - 46'(trim));
            if (dd == 27'sd0 && ((trav_ge && fac >= -16'sd1638 && fac <= 16'sd1638) ||
                                 near_d))
              mode_next = ST_DDONE;
            else mode_next = ST_DRIVE;
          end
          ST_DDONE: begin
            dreq_next   = 1'b0;
            done_next   = 1'b1;
            held_l_next = '0;
            held_r_next = '0;
            mode_next   = ST_IDLE;
          end
          ST_PSTART: mode_next = ST_PIVOT;
          ST_PIVOT: begin
            alast_next  = ep[23:0];
            held_r_next = sat_motor(speed);
            held_l_next = sat_motor(-speed);
            if (near64 || (near384 && dp == 27'sd0)) mode_next = ST_PDONE;
            else mode_next = ST_PIVOT;
          end
          ST_PDONE: begin
            preq_next   = 1'b0;
            done_next   = 1'b1;
            held_l_next = '0;
            held_r_next = '0;
            mode_next   = ST_IDLE;
          end
          ST_TELEOP: begin
            held_l_next = sat_motor(46'(ls));
            held_r_next = sat_motor(46'(rs));
            mode_next   = ST_TELEOP;
          end
          default: mode_next = ST_IDLE;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ST_INIT;
      dreq      <= 1'b0;
      preq      <= 1'b0;
      done      <= 1'b0;
      goal_dist <= '0;
      goal_head <= '0;
      goal_piv  <= '0;
      goal_spd  <= '0;
      dlast     <= '0;
      alast     <= '0;
      held_l    <= '0;
      held_r    <= '0;
    end else if (cmd.commit) begin
      mode      <= mode_next;
      dreq      <= dreq_next;
      preq      <= preq_next;
      done      <= done_next;
      goal_dist <= goal_dist_next;
      goal_head <= goal_head_next;
      goal_piv  <= goal_piv_next;
      goal_spd  <= goal_spd_next;
      dlast     <= dlast_next;
      alast     <= alast_next;
      held_l    <= held_l_next;
      held_r    <= held_r_next;
    end
  end

  assign result.left_motor     = held_l_next;
  assign result.right_motor    = held_r_next;
  assign result.reset_encoders = enc_pulse;
  assign result.clear_gyro     = gyro_pulse;
  assign result.mode_code      = mode_next;
  assign result.motion_done    = done_next;

endmodule

FILE: src/differential_drive_pd_controller.sv
// ----------------------------------------------------------------------------
// Differential drive PD controller
// Ten-state drive controller with PD distance and pivot loops.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: operation; tdata: sticks, distances, gyro, targets
//  m_axis    out        tdata: motors, pulses, mode, done flag
//  cfg       in         cfg_index selects a gain, dead zone or clamp register
//
// Each item passes through capture, error terms, five steps through the
// one shared 27x17 multiplier, then the write-back of state and result.
// A finished beat waits in the output register; the next item may be taken
// meanwhile, but its write-back waits for the output register to empty.
// Reset is synchronous and leaves the controller in its initialise state.
// Configuration writes are always taken.
module differential_drive_pd_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_stick, right_stick, left_distance, right_distance, gyro_angle,
  // target_distance, target_speed, target_angle
  input  logic [167:0] s_axis_tdata,
  // operation
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_motor, right_motor, reset_encoders, clear_gyro, mode_code,
  // motion_done, one zero pad bit
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [ddpd_pkg::RegIdxW-1:0] cfg_index,
  input  logic [15:0]  cfg_data
);
  import ddpd_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t result;
  result_t out_beat;
  logic    out_valid;

  assign cfg_ready      = 1'b1;
  assign stat.out_full  = out_valid;
  assign stat.out_taken = m_axis_tready;

  ddpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddpd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_op     (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_beat <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_beat.motion_done, out_beat.mode_code,
                          out_beat.clear_gyro, out_beat.reset_encoders,
                          out_beat.right_motor, out_beat.left_motor};

endmodule
